### rtl/core/tlpq_pkg.sv
package tlpq_pkg;

  localparam int DEF_LEVEL_DEPTH = 16;
  localparam int DEF_LEVEL_COUNT = 3;
  localparam int DATA_W          = 32;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_QUERY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_BAD_PRI = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FRONT,
    S_FINISH
  } state_t;

  // command handed to the pointer block for one transaction
  typedef struct packed {
    logic       exec;
    func_t      func;
    logic [1:0] pri;
  } tlpq_cmd_t;

  // outcome of the execute cycle
  typedef struct packed {
    status_t    status;
    logic       popped;
    logic [1:0] pop_pri;
  } tlpq_step_t;

endpackage

### rtl/core/tlpq_store.sv
module tlpq_store
  import tlpq_pkg::*;
#(
  parameter int DEPTH = DEF_LEVEL_DEPTH * DEF_LEVEL_COUNT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/tlpq_ptrs.sv
module tlpq_ptrs
  import tlpq_pkg::*;
#(
  parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
  parameter int LEVEL_COUNT = DEF_LEVEL_COUNT,
  localparam int ADDR_W = $clog2(LEVEL_DEPTH * LEVEL_COUNT),
  localparam int FILL_W = $clog2(LEVEL_DEPTH + 1),
  localparam int TOT_W  = $clog2(LEVEL_DEPTH * LEVEL_COUNT + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  tlpq_cmd_t         cmd,
  input  logic [1:0]        query_level,
  output tlpq_step_t        step,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [ADDR_W-1:0] pop_addr,
  output logic [ADDR_W-1:0] front_addr,
  output logic              front_busy,
  output logic [1:0]        front_pri,
  output logic [TOT_W-1:0]  total,
  output logic [FILL_W-1:0] level_cnt
);

  localparam int IDX_W = $clog2(LEVEL_DEPTH);
  localparam int LVL_W = $clog2(LEVEL_COUNT);

  logic [IDX_W-1:0]  head [LEVEL_COUNT];
  logic [IDX_W-1:0]  tail [LEVEL_COUNT];
  logic [FILL_W-1:0] fill [LEVEL_COUNT];

  logic [LVL_W-1:0] push_lvl;
  logic [LVL_W-1:0] busy_lvl;
  logic             pri_ok;
  logic             lvl_full;
  logic             push_ok;
  logic             pop_ok;

  function automatic logic [IDX_W-1:0] next_pos(logic [IDX_W-1:0] p);
    return (p == IDX_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] ent_addr(logic [LVL_W-1:0] lv,
                                                  logic [IDX_W-1:0] ix);
    return ADDR_W'(ADDR_W'(lv) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(ix);
  endfunction

  // lowest-numbered busy level (priority 1) wins
  always_comb begin
    front_busy = 1'b0;
    busy_lvl   = '0;
    for (int l = LEVEL_COUNT - 1; l >= 0; l--) begin
      if (fill[l] != '0) begin
        front_busy = 1'b1;
        busy_lvl   = LVL_W'(l);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      total = total + TOT_W'(fill[l]);
    end
  end

  always_comb begin
    level_cnt = '0;
    if (query_level != 2'd0 && 32'(query_level) <= LEVEL_COUNT) begin
      level_cnt = fill[LVL_W'(query_level - 2'd1)];
    end
  end

  assign push_lvl   = LVL_W'(cmd.pri - 2'd1);
  assign pri_ok     = (cmd.pri != 2'd0) && (32'(cmd.pri) <= LEVEL_COUNT);
  assign lvl_full   = (fill[push_lvl] == FILL_W'(LEVEL_DEPTH));
  assign push_ok    = cmd.exec && (cmd.func == FUNC_PUSH) && pri_ok && !lvl_full;
  assign pop_ok     = cmd.exec && (cmd.func == FUNC_POP) && front_busy;
  assign wr_en      = push_ok;
  assign wr_addr    = ent_addr(push_lvl, tail[push_lvl]);
  assign pop_addr   = ent_addr(busy_lvl, head[busy_lvl]);
  assign front_addr = pop_addr;
  assign front_pri  = 2'(32'(busy_lvl) + 1);

  always_comb begin
    step.status  = STAT_OK;
    step.popped  = 1'b0;
    step.pop_pri = 2'd0;
    unique case (cmd.func)
      FUNC_PUSH: begin
        if (!pri_ok) begin
          step.status = STAT_BAD_PRI;
        end else if (lvl_full) begin
          step.status = STAT_FULL;
        end
      end
      FUNC_POP: begin
        if (!front_busy) begin
          step.status = STAT_EMPTY;
        end else begin
          step.popped  = 1'b1;
          step.pop_pri = front_pri;
        end
      end
      FUNC_CLEAR, FUNC_QUERY: begin
        step.status = STAT_OK;
      end
      default: begin
        step.status = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.exec && cmd.func == FUNC_CLEAR)) begin
      for (int l = 0; l < LEVEL_COUNT; l++) begin
        head[l] <= '0;
        tail[l] <= '0;
        fill[l] <= '0;
      end
    end else if (push_ok) begin
      tail[push_lvl] <= next_pos(tail[push_lvl]);
      fill[push_lvl] <= fill[push_lvl] + 1'b1;
    end else if (pop_ok) begin
      head[busy_lvl] <= next_pos(head[busy_lvl]);
      fill[busy_lvl] <= fill[busy_lvl] - 1'b1;
    end
  end

endmodule

### rtl/core/three_level_priority_queue_unit.sv
// strict priority queue, three levels, fifo order within a level
// done strobes once an accepted transaction has passed through the execute, front
// and finish states; busy holds off a new start until the unit is idle again,
// since the single storage read port serves the pop read, then the front read
// reset (rst, synchronous): empties all levels; storage is not cleared
// results are not flow controlled: the receiver cannot stall done
module three_level_priority_queue_unit
  import tlpq_pkg::*;
#(
  parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
  parameter int LEVEL_COUNT = DEF_LEVEL_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic signed [31:0] push_value,
  input  logic [1:0]         push_priority,
  input  logic [1:0]         query_level,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] popped_value,
  output logic [1:0]         popped_priority,
  output logic signed [31:0] front_value,
  output logic [1:0]         front_priority,
  output logic [5:0]         total_count,
  output logic [4:0]         level_count,
  output logic               queue_empty
);

  localparam int DEPTH  = LEVEL_DEPTH * LEVEL_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
  localparam int TOT_W  = $clog2(DEPTH + 1);

  state_t state;
  state_t state_next;

  // transaction latched at accept
  func_t             func_q;
  logic [1:0]        pri_q;
  logic [1:0]        ql_q;
  logic [31:0]       value_q;

  tlpq_cmd_t         cmd;
  tlpq_step_t        step;
  tlpq_step_t        step_q;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] pop_addr;
  logic [ADDR_W-1:0] front_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       rd_data;
  logic              front_busy;
  logic [1:0]        front_pri;
  logic [TOT_W-1:0]  total;
  logic [FILL_W-1:0] level_cnt;

  logic              accept;
  logic              exec;

  assign accept = start && !busy;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_EXEC;
      S_EXEC:   state_next = S_FRONT;
      S_FRONT:  state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy = 1'b1;
    exec = 1'b0;
    unique case (state)
      S_IDLE:   busy = 1'b0;
      S_EXEC:   exec = 1'b1;
      S_FRONT:  exec = 1'b0;
      S_FINISH: exec = 1'b0;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= func_t'(func);
      pri_q   <= push_priority;
      ql_q    <= query_level;
      value_q <= push_value;
    end
  end

  assign cmd.exec = exec;
  assign cmd.func = func_q;
  assign cmd.pri  = pri_q;

  tlpq_ptrs #(
    .LEVEL_DEPTH(LEVEL_DEPTH),
    .LEVEL_COUNT(LEVEL_COUNT)
  ) u_ptrs (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .query_level (ql_q),
    .step        (step),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .pop_addr    (pop_addr),
    .front_addr  (front_addr),
    .front_busy  (front_busy),
    .front_pri   (front_pri),
    .total       (total),
    .level_cnt   (level_cnt)
  );

  // pop read during execute, front read once the pointers have moved
  assign rd_addr = exec ? pop_addr : front_addr;

  tlpq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value_q),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (exec) begin
      step_q <= step;
    end
  end

  // popped entry arrives while in front state
  always_ff @(posedge clk) begin
    if (state == S_FRONT) begin
      popped_value <= step_q.popped ? $signed(rd_data) : 32'sd0;
    end
  end

  // front entry arrives in finish state; publish the whole result
  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      status          <= step_q.status;
      popped_priority <= step_q.pop_pri;
      front_value     <= front_busy ? $signed(rd_data) : 32'sd0;
      front_priority  <= front_busy ? front_pri : 2'd0;
      total_count     <= 6'(total);
      level_count     <= 5'(level_cnt);
      queue_empty     <= (total == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_FINISH);
    end
  end

endmodule

### bench/three_level_priority_queue_unit_test.sv
`timescale 1ns / 1ps

module three_level_priority_queue_unit_test;
  import tlpq_pkg::*;

  localparam int LEVELS       = DEF_LEVEL_COUNT;
  localparam int DEPTH        = DEF_LEVEL_DEPTH;
  localparam int SLOT_W       = $clog2(DEPTH);
  localparam int HELD_W       = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1850;
  localparam int MAX_PRINTED  = 40;

  // one queue command as presented on the input ports
  typedef struct packed {
    func_t              op;
    logic signed [31:0] value;
    logic [1:0]         pri;
    logic [1:0]         level;
  } queue_cmd_t;

  // one reply as seen on the result ports
  typedef struct packed {
    status_t            status;
    logic signed [31:0] pop_value;
    logic [1:0]         pop_pri;
    logic signed [31:0] head_value;
    logic [1:0]         head_pri;
    logic [5:0]         total;
    logic [4:0]         lvl_cnt;
    logic               empty;
  } queue_reply_t;

  // dut ports; the inputs are all known from time zero
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         func = FUNC_QUERY;
  logic signed [31:0] push_value = '0;
  logic [1:0]         push_priority = '0;
  logic [1:0]         query_level = '0;
  logic               busy;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] popped_value;
  logic [1:0]         popped_priority;
  logic signed [31:0] front_value;
  logic [1:0]         front_priority;
  logic [5:0]         total_count;
  logic [4:0]         level_count;
  logic               queue_empty;

  // commands waiting to be issued, and replies the queue still owes us
  queue_cmd_t   cmd_backlog[$];
  queue_reply_t reply_backlog[$];
  int           mismatch_count = 0;

  // shadow copy of the per-level fifos
  logic [31:0]       slot_mem[LEVELS][DEPTH];
  logic [SLOT_W-1:0] head_slot[LEVELS];
  logic [SLOT_W-1:0] tail_slot[LEVELS];
  logic [HELD_W-1:0] held_cnt[LEVELS];

  // sender burst / gap bookkeeping
  int burst_left = 0;
  int gap_left = 0;

  three_level_priority_queue_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .push_value     (push_value),
    .push_priority  (push_priority),
    .query_level    (query_level),
    .done           (done),
    .status         (status),
    .popped_value   (popped_value),
    .popped_priority(popped_priority),
    .front_value    (front_value),
    .front_priority (front_priority),
    .total_count    (total_count),
    .level_count    (level_count),
    .queue_empty    (queue_empty)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the queue hangs
  initial begin
    #5ms;
    $display("three_level_priority_queue_unit verification failed");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTED) $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%08h want 0x%08h", name, got, want));
    end
  endtask

  // ---------------------------------------------------------------------------
  // shadow fifo model
  // ---------------------------------------------------------------------------

  function automatic void empty_levels();
    for (int l = 0; l < LEVELS; l++) begin
      head_slot[l] = '0;
      tail_slot[l] = '0;
      held_cnt[l]  = '0;
    end
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  // highest priority level holding anything, -1 when all are empty
  function automatic int first_held_level();
    for (int l = 0; l < LEVELS; l++) begin
      if (held_cnt[l] != 0) return l;
    end
    return -1;
  endfunction

  function automatic queue_reply_t predict_queue_step(queue_cmd_t c);
    queue_reply_t r;
    int lv;
    int total;
    r = '0;
    r.status = STAT_OK;
    case (c.op)
      FUNC_PUSH: begin
        if (c.pri == 0 || int'(c.pri) > LEVELS) begin
          r.status = STAT_BAD_PRI;
        end else begin
          lv = int'(c.pri) - 1;
          if (int'(held_cnt[lv]) >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            slot_mem[lv][tail_slot[lv]] = c.value;
            tail_slot[lv] = next_slot(tail_slot[lv]);
            held_cnt[lv]++;
          end
        end
      end
      FUNC_POP: begin
        lv = first_held_level();
        if (lv < 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.pop_value = slot_mem[lv][head_slot[lv]];
          r.pop_pri = 2'(lv + 1);
          head_slot[lv] = next_slot(head_slot[lv]);
          held_cnt[lv]--;
        end
      end
      FUNC_CLEAR: empty_levels();
      default: ;
    endcase

    // front and counts reflect the state after this step
    lv = first_held_level();
    if (lv >= 0) begin
      r.head_value = slot_mem[lv][head_slot[lv]];
      r.head_pri = 2'(lv + 1);
    end
    total = 0;
    for (int l = 0; l < LEVELS; l++) total += held_cnt[l];
    r.total = 6'(total);
    if (c.level >= 1 && int'(c.level) <= LEVELS) r.lvl_cnt = 5'(held_cnt[int'(c.level) - 1]);
    r.empty = (total == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_cmd(func_t op, logic [31:0] value, logic [1:0] pri, logic [1:0] level);
    queue_cmd_t c;
    c.op = op;
    c.value = value;
    c.pri = pri;
    c.level = level;
    cmd_backlog.push_back(c);
  endtask

  // mostly random words, now and then a corner value
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // query level 0 shows up now and then, it must report zero
  function automatic logic [1:0] pick_level();
    return ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
  endfunction

  function automatic logic [1:0] pick_pri();
    return ($urandom_range(0, 19) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int n;
    int lvl;
    int push_pct;
    int roll;

    // directed: empty queue, bad priority, extremes on every level
    add_cmd(FUNC_QUERY, 32'h0, 2'd1, 2'd0);
    add_cmd(FUNC_POP,   32'h0, 2'd1, 2'd1);
    add_cmd(FUNC_PUSH,  32'h1234_5678, 2'd0, 2'd1);
    add_cmd(FUNC_PUSH,  32'h7fff_ffff, 2'd1, 2'd1);
    add_cmd(FUNC_PUSH,  32'h8000_0000, 2'd3, 2'd3);
    add_cmd(FUNC_PUSH,  32'h0000_0000, 2'd2, 2'd2);
    add_cmd(FUNC_PUSH,  32'hffff_ffff, 2'd2, 2'd2);
    add_cmd(FUNC_PUSH,  32'h5555_5555, 2'd1, 2'd0);
    add_cmd(FUNC_QUERY, 32'haaaa_aaaa, 2'd3, 2'd3);
    // drain in priority order, then one pop too many
    add_cmd(FUNC_POP,   32'h0, 2'd0, 2'd1);
    add_cmd(FUNC_POP,   32'h0, 2'd0, 2'd2);
    add_cmd(FUNC_POP,   32'h0, 2'd0, 2'd2);
    add_cmd(FUNC_POP,   32'h0, 2'd0, 2'd3);
    add_cmd(FUNC_POP,   32'h0, 2'd0, 2'd3);
    add_cmd(FUNC_POP,   32'h0, 2'd0, 2'd1);
    // clear with items on several levels
    add_cmd(FUNC_PUSH,  32'haaaa_aaaa, 2'd3, 2'd3);
    add_cmd(FUNC_PUSH,  32'h0000_0001, 2'd1, 2'd1);
    add_cmd(FUNC_CLEAR, 32'hffff_ffff, 2'd3, 2'd1);
    add_cmd(FUNC_QUERY, 32'h0, 2'd0, 2'd2);
    add_cmd(FUNC_POP,   32'h0, 2'd2, 2'd3);
    add_cmd(FUNC_PUSH,  32'h1357_9bdf, 2'd2, 2'd2);
    add_cmd(FUNC_POP,   32'h0, 2'd0, 2'd2);

    // random part built from whole sequences
    n = cmd_backlog.size() + RANDOM_ITEMS;
    while (cmd_backlog.size() < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // pile onto one level, often far enough to hit full
          lvl = $urandom_range(1, 3);
          repeat ($urandom_range(10, 20)) add_cmd(FUNC_PUSH, pick_value(), 2'(lvl), pick_level());
        end
        2: begin
          // drain, sometimes past empty
          repeat ($urandom_range(1, 52)) add_cmd(FUNC_POP, $urandom, 2'($urandom), pick_level());
        end
        3: begin
          // noise on every field
          repeat ($urandom_range(1, 8)) begin
            add_cmd(func_t'($urandom_range(0, 3)), $urandom, 2'($urandom), 2'($urandom));
          end
        end
        default: begin
          // mixed traffic with a push bias picked per stretch
          push_pct = $urandom_range(20, 80);
          repeat ($urandom_range(10, 40)) begin
            roll = $urandom_range(0, 99);
            if (roll < 1) add_cmd(FUNC_CLEAR, $urandom, 2'($urandom), pick_level());
            else if (roll < push_pct) add_cmd(FUNC_PUSH, pick_value(), pick_pri(), pick_level());
            else if (roll < 95) add_cmd(FUNC_POP, $urandom, 2'($urandom), pick_level());
            else add_cmd(FUNC_QUERY, $urandom, 2'($urandom), pick_level());
          end
        end
      endcase
    end

    // hold reset, then release it
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // wait for all commands to be taken and all replies checked
    @(negedge clk);
    while (cmd_backlog.size() != 0 || start || reply_backlog.size() != 0) @(negedge clk);
    // wait on to catch any stray done
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("three_level_priority_queue_unit verification clean");
    end else begin
      $display("three_level_priority_queue_unit verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: bursts of commands separated by random gaps
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    logic presenting;
    if (rst) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      presenting = start;
      // transaction taken at this edge
      if (start && !busy) begin
        void'(cmd_backlog.pop_front());
        presenting = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // new burst; a quarter of them follow with no gap at all
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!presenting) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() != 0) begin
          func          <= cmd_backlog[0].op;
          push_value    <= cmd_backlog[0].value;
          push_priority <= cmd_backlog[0].pri;
          query_level   <= cmd_backlog[0].level;
          presenting = 1'b1;
        end
      end
      // single update of start per edge
      start <= presenting;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks replies first, then records the transaction taken this edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    queue_reply_t want;
    queue_cmd_t   taken;
    if (rst) begin
      reply_backlog.delete();
      empty_levels();
    end else begin
      if (done) begin
        if (reply_backlog.size() == 0) begin
          report_mismatch("done with no transaction outstanding");
        end else begin
          want = reply_backlog.pop_front();
          check_field("status", status, want.status);
          check_field("popped_value", popped_value, want.pop_value);
          check_field("popped_priority", popped_priority, want.pop_pri);
          check_field("front_value", front_value, want.head_value);
          check_field("front_priority", front_priority, want.head_pri);
          check_field("total_count", total_count, want.total);
          check_field("level_count", level_count, want.lvl_cnt);
          check_field("queue_empty", queue_empty, want.empty);
        end
      end
      // ports still hold the accepted command here
      if (start && !busy) begin
        taken.op    = func_t'(func);
        taken.value = push_value;
        taken.pri   = push_priority;
        taken.level = query_level;
        reply_backlog.push_back(predict_queue_step(taken));
      end
    end
  end

endmodule
